### src/assert_macros.svh
// Assertion macros shared by the gaussian filter RTL.
// No dependencies; define SYNTH to compile the checks out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked check that also holds while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### src/gauss3_pkg.sv
// Shared constants, types and helper functions of the 3x3 gaussian filter.
// No dependencies.
package gauss3_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_DIM        = 3;
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int WIDTH_W        = 12;
  localparam int HEIGHT_W       = 13;
  localparam int ADDR_W         = $clog2(MAX_WIDTH);
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int PEND_W         = $clog2(MAX_WIDTH + 2);
  localparam int TAP_SUM_W      = PIX_W + 2;
  localparam int PROD_W         = TAP_SUM_W + COEF_W;
  localparam int CTR_W          = PIX_W + COEF_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int PIX_MAX        = 255;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CORNER  = 3'd4;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic [COEF_W-1:0] center;
    logic [COEF_W-1:0] edge_w;
    logic [COEF_W-1:0] corner;
  } coef_t;

  typedef struct packed {
    logic [PROD_W-1:0] corner;
    logic [PROD_W-1:0] edge_p;
    logic [CTR_W-1:0]  center;
  } prod_t;

  typedef struct packed {
    logic shift;  // a pixel leaves the first stage: advance the window
    logic load;   // the first stage moves on: capture the products
  } kernel_ctrl_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    if (v < WIDTH_W'(MIN_DIM)) begin
      r = WIDTH_W'(MIN_DIM);
    end else if (v > WIDTH_W'(MAX_WIDTH)) begin
      r = WIDTH_W'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] r;
    if (v < HEIGHT_W'(MIN_DIM)) begin
      r = HEIGHT_W'(MIN_DIM);
    end else if (v > HEIGHT_W'(MAX_HEIGHT)) begin
      r = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### src/gauss3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gauss3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/gauss3_kernel.sv
// 3x3 window registers and the weighted products of the gaussian filter.
// Depends on gauss3_pkg.
module gauss3_kernel (
  input  logic                          clk,
  input  logic                          rst,
  input  gauss3_pkg::kernel_ctrl_t      ctrl,
  input  gauss3_pkg::coef_t             coef,
  input  logic [gauss3_pkg::PIX_W-1:0]  top,
  input  logic [gauss3_pkg::PIX_W-1:0]  mid,
  input  logic [gauss3_pkg::PIX_W-1:0]  bot,
  output gauss3_pkg::prod_t             prod
);

  // Taps 0..2 hold the oldest column (top, mid, bottom), taps 3..5 the next one.
  logic [gauss3_pkg::PIX_W-1:0]     win [6];
  logic [gauss3_pkg::TAP_SUM_W-1:0] corners;
  logic [gauss3_pkg::TAP_SUM_W-1:0] edges;
  gauss3_pkg::prod_t                prod_next;

  always_comb begin
    corners = gauss3_pkg::TAP_SUM_W'(win[0]) + gauss3_pkg::TAP_SUM_W'(win[2])
            + gauss3_pkg::TAP_SUM_W'(top) + gauss3_pkg::TAP_SUM_W'(bot);
    edges   = gauss3_pkg::TAP_SUM_W'(win[1]) + gauss3_pkg::TAP_SUM_W'(win[3])
            + gauss3_pkg::TAP_SUM_W'(win[5]) + gauss3_pkg::TAP_SUM_W'(mid);
    prod_next.corner = gauss3_pkg::PROD_W'(corners) * gauss3_pkg::PROD_W'(coef.corner);
    prod_next.edge_p = gauss3_pkg::PROD_W'(edges) * gauss3_pkg::PROD_W'(coef.edge_w);
    prod_next.center = gauss3_pkg::CTR_W'(win[4]) * gauss3_pkg::CTR_W'(coef.center);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (ctrl.shift) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= prod_next;
    end
  end

endmodule

### src/gaussian_3x3_filter.sv
// Top level of the 3x3 gaussian smoothing filter for 8-bit grey pixel streams.
// Depends on gauss3_pkg, gauss3_ram, gauss3_kernel and assert_macros.svh.
//
// Usage. Pixels arrive in raster order on the pix channel (pix_valid, pix_stall,
// action, pixel_in); a beat is taken at a clock edge with pix_valid high and
// pix_stall low. Results leave on the res channel (res_valid, res_stall,
// filtered_pixel, frame_end) under the same rule. Each result belongs to the
// position one row plus one pixel behind the newest pixel, so after the last
// pixel of a frame the source sends width+1 flush beats (action high) to drain
// the rest; frame_end marks the last drained position. Border positions give 0.
// A flush beat with nothing left to drain is taken and produces nothing.
//
// Timing. The block takes one beat per clock while pix_stall is low. The row store
// read is launched at the accepting edge beside the stage 1 register; the window
// multiplies are registered in the kernel, and the sum, shift and clamp feed the
// output register. The rate is set by the two row stores, each doing one read
// and one write per pixel. A stalled result holds the output register; the
// stages in front keep taking beats until they fill up, then pix_stall rises.
//
// Reset (synchronous, active high) clears the pipeline, the position counters,
// the drain count and the window, and loads the default geometry and weights.
// The row stores are not cleared; unwritten data feeds only border results.
// Configuration writes belong in idle periods; the block does not check for that.
`include "assert_macros.svh"

module gaussian_3x3_filter (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [gauss3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gauss3_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel input channel
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  logic                               action,
  input  logic [gauss3_pkg::PIX_W-1:0]       pixel_in,
  // result channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [gauss3_pkg::PIX_W-1:0]       filtered_pixel,
  output logic                               frame_end
);

  // Configuration registers.
  logic [gauss3_pkg::WIDTH_W-1:0]  frame_width;
  logic [gauss3_pkg::HEIGHT_W-1:0] frame_height;
  gauss3_pkg::coef_t               coef;

  logic [gauss3_pkg::WIDTH_W-1:0]  w_eff;
  logic [gauss3_pkg::HEIGHT_W-1:0] h_eff;

  // Position of the next pixel and the count of results still owed to flush beats.
  logic [gauss3_pkg::ADDR_W-1:0]   column_count;
  logic [gauss3_pkg::ROW_W-1:0]    row_count;
  logic [gauss3_pkg::PEND_W-1:0]   pending_outputs;
  logic [gauss3_pkg::ADDR_W-1:0]   column_count_next;
  logic [gauss3_pkg::ROW_W-1:0]    row_count_next;
  logic [gauss3_pkg::PEND_W-1:0]   pending_outputs_next;

  // Stage 1: the accepted beat, with the row store data arriving alongside.
  logic                            s1_valid;
  logic                            s1_pixel;
  logic                            s1_emit;
  logic                            s1_interior;
  logic                            s1_last;
  logic [gauss3_pkg::PIX_W-1:0]    s1_bot;
  logic [gauss3_pkg::ADDR_W-1:0]   s1_addr;
  logic                            s1_ready;

  // Stage 2: products held in the kernel.
  logic                            s2_valid;
  logic                            s2_interior;
  logic                            s2_last;
  logic                            s2_ready;
  logic                            out_ready;

  logic                            pix_acc;
  logic                            acc_enters;
  logic                            acc_emit;
  logic                            acc_interior;
  logic                            acc_last;

  logic [gauss3_pkg::PIX_W-1:0]    top_data;
  logic [gauss3_pkg::PIX_W-1:0]    mid_data;
  logic                            store_we;

  gauss3_pkg::kernel_ctrl_t        kctrl;
  gauss3_pkg::prod_t               prod;
  logic [gauss3_pkg::SUM_W-1:0]    sum;
  logic [gauss3_pkg::SUM_W-gauss3_pkg::COEF_FRAC_BITS-1:0] quotient;
  logic [gauss3_pkg::PIX_W-1:0]    clamped;

  assign w_eff = gauss3_pkg::clamp_width(frame_width);
  assign h_eff = gauss3_pkg::clamp_height(frame_height);

  // Ready ripples back from the output register through the two stages.
  assign out_ready = !res_valid || !res_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pix_stall = !s1_ready;
  assign pix_acc   = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gauss3_pkg::WIDTH_W'(640);
      frame_height <= gauss3_pkg::HEIGHT_W'(480);
      coef.center  <= gauss3_pkg::COEF_W'(13381);
      coef.edge_w  <= gauss3_pkg::COEF_W'(8116);
      coef.corner  <= gauss3_pkg::COEF_W'(4922);
    end else if (cfg_write) begin
      case (cfg_index)
        gauss3_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[gauss3_pkg::WIDTH_W-1:0];
        gauss3_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[gauss3_pkg::HEIGHT_W-1:0];
        gauss3_pkg::CFG_COEF_CENTER:  coef.center  <= cfg_data[gauss3_pkg::COEF_W-1:0];
        gauss3_pkg::CFG_COEF_EDGE:    coef.edge_w  <= cfg_data[gauss3_pkg::COEF_W-1:0];
        gauss3_pkg::CFG_COEF_CORNER:  coef.corner  <= cfg_data[gauss3_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Position bookkeeping for the beat on the input. A pixel at (r, c) produces
  // the result for (r-1, c-1); that position is interior exactly when
  // 2 <= r < height and 2 <= c < width. Column 0 results land on the right
  // border and are always zero.
  always_comb begin
    column_count_next    = column_count;
    row_count_next       = row_count;
    pending_outputs_next = pending_outputs;
    acc_enters           = 1'b0;
    acc_emit             = 1'b0;
    acc_interior         = 1'b0;
    acc_last             = 1'b0;
    if (action == gauss3_pkg::ACT_FLUSH) begin
      if (pending_outputs != '0) begin
        pending_outputs_next = pending_outputs - gauss3_pkg::PEND_W'(1);
        acc_enters           = 1'b1;
        acc_emit             = 1'b1;
        acc_last             = (pending_outputs == gauss3_pkg::PEND_W'(1));
      end
    end else begin
      acc_enters           = 1'b1;
      pending_outputs_next = '0;
      acc_emit     = (row_count >= gauss3_pkg::ROW_W'(2))
                  || ((row_count == gauss3_pkg::ROW_W'(1)) && (column_count != '0));
      acc_interior = (row_count >= gauss3_pkg::ROW_W'(2))
                  && ({1'b0, row_count} < h_eff)
                  && (column_count >= gauss3_pkg::ADDR_W'(2))
                  && ({1'b0, column_count} < w_eff);
      if ({1'b0, column_count} >= w_eff - gauss3_pkg::WIDTH_W'(1)) begin
        column_count_next = '0;
        if ({1'b0, row_count} >= h_eff - gauss3_pkg::HEIGHT_W'(1)) begin
          row_count_next       = '0;
          pending_outputs_next = gauss3_pkg::PEND_W'(w_eff) + gauss3_pkg::PEND_W'(1);
        end else begin
          row_count_next = row_count + gauss3_pkg::ROW_W'(1);
        end
      end else begin
        column_count_next = column_count + gauss3_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      pending_outputs <= '0;
    end else if (pix_acc) begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      pending_outputs <= pending_outputs_next;
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pix_acc && acc_enters;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pix_acc) begin
      s1_pixel    <= (action == gauss3_pkg::ACT_PIXEL);
      s1_emit     <= acc_emit;
      s1_interior <= acc_interior;
      s1_last     <= acc_last;
      s1_bot      <= pixel_in;
      s1_addr     <= column_count;
    end
  end

  // The row stores are read for the incoming beat and written back as the
  // pixel leaves stage 1; consecutive pixels never share a column.
  assign store_we = s1_valid && s1_pixel && s2_ready;

  gauss3_ram #(
    .WIDTH (gauss3_pkg::PIX_W),
    .DEPTH (gauss3_pkg::MAX_WIDTH)
  ) u_row_store_upper (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_addr),
    .wdata (mid_data),
    .re    (pix_acc),
    .raddr (column_count),
    .rdata (top_data)
  );

  gauss3_ram #(
    .WIDTH (gauss3_pkg::PIX_W),
    .DEPTH (gauss3_pkg::MAX_WIDTH)
  ) u_row_store_lower (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_addr),
    .wdata (s1_bot),
    .re    (pix_acc),
    .raddr (column_count),
    .rdata (mid_data)
  );

  assign kctrl.shift = store_we;
  assign kctrl.load  = s1_valid && s2_ready;

  gauss3_kernel u_kernel (
    .clk  (clk),
    .rst  (rst),
    .ctrl (kctrl),
    .coef (coef),
    .top  (top_data),
    .mid  (mid_data),
    .bot  (s1_bot),
    .prod (prod)
  );

  // Stage 2 control travels beside the products held in the kernel.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_interior <= s1_interior;
      s2_last     <= s1_last;
    end
  end

  // Sum of the three products, drop the fraction bits and saturate to a pixel.
  always_comb begin
    sum = gauss3_pkg::SUM_W'(prod.corner) + gauss3_pkg::SUM_W'(prod.edge_p)
        + gauss3_pkg::SUM_W'(prod.center);
    quotient = sum[gauss3_pkg::SUM_W-1:gauss3_pkg::COEF_FRAC_BITS];
    if (quotient > ($bits(quotient))'(gauss3_pkg::PIX_MAX)) begin
      clamped = gauss3_pkg::PIX_W'(gauss3_pkg::PIX_MAX);
    end else begin
      clamped = quotient[gauss3_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      filtered_pixel <= s2_interior ? clamped : '0;
      frame_end      <= s2_last;
    end
  end

  // Drained positions are all on the border.
  `ASSERT_CLK(a_frame_end_zero, clk, rst, res_valid && frame_end |-> filtered_pixel == '0)
  // Results are owed only right after a frame wrapped the counters.
  `ASSERT_CLK(a_pending_at_origin, clk, rst,
    pending_outputs != '0 |-> column_count == '0 && row_count == '0)
  // A blocked stage 1 keeps its beat, so the row store write is not lost.
  `ASSERT_CLK(a_s1_hold, clk, rst, s1_valid && !s2_ready |=> s1_valid && $stable(s1_addr))
  // Every accepted pixel reaches stage 1.
  `ASSERT_CLK(a_pixel_enters, clk, rst,
    pix_acc && action == gauss3_pkg::ACT_PIXEL |=> s1_valid && s1_pixel)

endmodule
